@@ design/pdb_pkg.sv @@
// pdb_pkg: shared widths, codes, reset values and the result beat layout
// for the press delay debouncer bank. depends on nothing.
package pdb_pkg;

  localparam int BTN_W      = 8;
  localparam int AXIS_W     = 2;
  localparam int NOW_W      = 32;
  localparam int DELAY_W    = 16;
  localparam int IN_FIELD_W = BTN_W + 1 + 1 + AXIS_W + AXIS_W + NOW_W;
  localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = BTN_W + 1 + 1 + AXIS_W + AXIS_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int NUM_BUTTONS_DEF = 8;
  localparam int TIME_BITS_DEF   = 32;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd20;

  // three-way direction codes, two's complement
  localparam logic [AXIS_W-1:0] AXIS_IDLE = 2'b00;
  localparam logic [AXIS_W-1:0] AXIS_POS  = 2'b01;
  localparam logic [AXIS_W-1:0] AXIS_NEG  = 2'b11;

  // first member sits in the top bits, so buttons land lowest
  typedef struct packed {
    logic [AXIS_W-1:0] axis_y;
    logic [AXIS_W-1:0] axis_x;
    logic              right_trigger;
    logic              left_trigger;
    logic [BTN_W-1:0]  buttons;
  } result_t;

  typedef struct packed {
    logic out_valid;
    logic skid_valid;
  } stage_stat_t;

endpackage

@@ design/pdb_bit_lane.sv @@
// pdb_bit_lane: debounce of one bit channel, instant release, delayed press.
// depends on pdb_pkg for the delay width.
module pdb_bit_lane #(
  parameter int TIME_BITS = pdb_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         raw,
  input  logic [TIME_BITS-1:0]         now,
  input  logic [pdb_pkg::DELAY_W-1:0]  delay,
  output logic                         q
);

  logic                 stable_r, stable_nxt;
  logic                 cand_r, cand_nxt;
  logic [TIME_BITS-1:0] since_r, since_nxt;
  logic [TIME_BITS-1:0] elapsed;
  logic                 held;

  assign elapsed = now - since_r;
  assign held    = elapsed >= TIME_BITS'(delay);

  always_comb begin
    stable_nxt = stable_r;
    cand_nxt   = raw;
    since_nxt  = now;
    if (raw == stable_r) begin
      stable_nxt = stable_r;
    end else if (!raw) begin
      stable_nxt = 1'b0;
    end else if (cand_r != raw) begin
      stable_nxt = stable_r;
    end else begin
      // candidate still held: keep its start time
      since_nxt = since_r;
      if (held) begin
        stable_nxt = 1'b1;
      end
    end
  end

  assign q = stable_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      cand_r   <= 1'b0;
      since_r  <= '0;
    end else if (en) begin
      stable_r <= stable_nxt;
      cand_r   <= cand_nxt;
      since_r  <= since_nxt;
    end
  end

endmodule

@@ design/pdb_axis_lane.sv @@
// pdb_axis_lane: debounce of one three-way axis, drop on release or reversal.
// depends on pdb_pkg for the direction codes and delay width.
module pdb_axis_lane #(
  parameter int TIME_BITS = pdb_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [pdb_pkg::AXIS_W-1:0]   raw,
  input  logic [TIME_BITS-1:0]         now,
  input  logic [pdb_pkg::DELAY_W-1:0]  delay,
  output logic [pdb_pkg::AXIS_W-1:0]   q
);

  logic [pdb_pkg::AXIS_W-1:0] dir;
  logic [pdb_pkg::AXIS_W-1:0] stable_r, stable_nxt;
  logic [pdb_pkg::AXIS_W-1:0] cand_r, cand_nxt;
  logic [TIME_BITS-1:0]       since_r, since_nxt;
  logic [TIME_BITS-1:0]       elapsed;
  logic                       held;

  // the unused pattern 10 saturates to minus one
  always_comb begin
    unique case (raw)
      pdb_pkg::AXIS_IDLE: dir = pdb_pkg::AXIS_IDLE;
      pdb_pkg::AXIS_POS:  dir = pdb_pkg::AXIS_POS;
      default:            dir = pdb_pkg::AXIS_NEG;
    endcase
  end

  assign elapsed = now - since_r;
  assign held    = elapsed >= TIME_BITS'(delay);

  always_comb begin
    stable_nxt = stable_r;
    cand_nxt   = dir;
    since_nxt  = now;
    if (dir == stable_r) begin
      stable_nxt = stable_r;
    end else if (dir == pdb_pkg::AXIS_IDLE || stable_r != pdb_pkg::AXIS_IDLE) begin
      stable_nxt = pdb_pkg::AXIS_IDLE;
    end else if (cand_r != dir) begin
      stable_nxt = stable_r;
    end else begin
      since_nxt = since_r;
      if (held) begin
        stable_nxt = dir;
      end
    end
  end

  assign q = stable_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= pdb_pkg::AXIS_IDLE;
      cand_r   <= pdb_pkg::AXIS_IDLE;
      since_r  <= '0;
    end else if (en) begin
      stable_r <= stable_nxt;
      cand_r   <= cand_nxt;
      since_r  <= since_nxt;
    end
  end

endmodule

@@ design/pdb_merge.sv @@
// pdb_merge: gathers the lane results into one beat and holds it in an
// output register backed by a skid register. depends on pdb_pkg.
module pdb_merge (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_fire,
  input  pdb_pkg::result_t                res,
  output logic                            in_tready,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pdb_pkg::OUT_DATA_W-1:0]  out_tdata,
  output pdb_pkg::stage_stat_t            stat
);

  pdb_pkg::result_t out_data_r, out_data_nxt;
  pdb_pkg::result_t skid_data_r, skid_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic             out_fire;

  assign in_tready = !skid_valid_r;
  assign out_fire  = out_valid_r && out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_fire) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (in_fire) begin
        out_data_nxt = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r) begin
        // output stalled: park the new beat
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid      = out_valid_r;
  assign out_tdata       = pdb_pkg::OUT_DATA_W'(out_data_r);
  assign stat.out_valid  = out_valid_r;
  assign stat.skid_valid = skid_valid_r;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output register is empty");

  a_stall_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && out_valid_r && !out_tready) |=> (skid_valid_r && skid_data_r == $past(res)))
    else $error("beat taken during stall was not parked");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && skid_valid_r) |=> (out_valid_r && out_data_r == $past(skid_data_r)))
    else $error("parked beat did not move to the output register");

  a_no_fire_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !in_fire)
    else $error("beat accepted with skid register full");
`endif

endmodule

@@ design/press_delay_debouncer_bank.sv @@
// press_delay_debouncer_bank: top level, one lane per button and trigger,
// one per axis, merged into a registered result beat. depends on pdb_pkg.
//
//  channel | dir | tdata fields, lowest bit first
//  in_     | in  | buttons_raw[7:0] left_trigger_raw[8] right_trigger_raw[9]
//          |     | axis_x_raw[11:10] axis_y_raw[13:12] now_ms[45:14], pad to 48
//  out_    | out | buttons_out[7:0] left_trigger_out[8] right_trigger_out[9]
//          |     | axis_x_out[11:10] axis_y_out[13:12], pad to 16
//  cfg_    | in  | press_delay_ms[15:0], written when cfg_we is high
//
// one sample per cycle while in_tready is high; one subtract and compare per lane
// per beat; if out_ is not stalled, the result is on out_ the cycle after the beat.
// rst_n low clears every lane state, empties the output stage, delay back to 20.
// a stalled output keeps one more beat in the skid register; in_tready falls
// only when both the output and skid registers are full.
module press_delay_debouncer_bank #(
  parameter int NUM_BUTTONS = pdb_pkg::NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = pdb_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // buttons_raw, left_trigger_raw, right_trigger_raw, axis_x_raw, axis_y_raw, now_ms
  input  logic [pdb_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // buttons_out, left_trigger_out, right_trigger_out, axis_x_out, axis_y_out
  output logic [pdb_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_we,
  input  logic [pdb_pkg::DELAY_W-1:0]     cfg_wdata
);

  localparam int BTN_W = pdb_pkg::BTN_W;

  logic [pdb_pkg::DELAY_W-1:0] delay_r;
  logic                        in_fire;
  logic [BTN_W-1:0]            f_buttons;
  logic                        f_lt, f_rt;
  logic [pdb_pkg::AXIS_W-1:0]  f_ax, f_ay;
  logic [pdb_pkg::NOW_W-1:0]   f_now;
  logic [TIME_BITS-1:0]        now_w;
  logic [NUM_BUTTONS-1:0]      btn_q;
  logic [BTN_W-1:0]            btn_out;
  logic                        lt_q, rt_q;
  logic [pdb_pkg::AXIS_W-1:0]  ax_q, ay_q;
  pdb_pkg::result_t            res;
  pdb_pkg::stage_stat_t        stat;

  assign f_buttons = in_tdata[BTN_W-1:0];
  assign f_lt      = in_tdata[BTN_W];
  assign f_rt      = in_tdata[BTN_W+1];
  assign f_ax      = in_tdata[BTN_W+3:BTN_W+2];
  assign f_ay      = in_tdata[BTN_W+5:BTN_W+4];
  assign f_now     = in_tdata[BTN_W+6+pdb_pkg::NOW_W-1:BTN_W+6];
  assign now_w     = TIME_BITS'(f_now);

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= pdb_pkg::DELAY_RESET;
    end else if (cfg_we) begin
      delay_r <= cfg_wdata;
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    logic raw;
    if (i < BTN_W) begin : g_wired
      assign raw = f_buttons[i];
    end else begin : g_absent
      assign raw = 1'b0;
    end
    pdb_bit_lane #(.TIME_BITS(TIME_BITS)) u_lane (
      .clk(clk), .rst_n(rst_n), .en(in_fire), .raw(raw),
      .now(now_w), .delay(delay_r), .q(btn_q[i])
    );
  end

  for (genvar j = 0; j < BTN_W; j++) begin : g_bout
    if (j < NUM_BUTTONS) begin : g_used
      assign btn_out[j] = btn_q[j];
    end else begin : g_unused
      assign btn_out[j] = 1'b0;
    end
  end

  pdb_bit_lane #(.TIME_BITS(TIME_BITS)) u_lt (
    .clk(clk), .rst_n(rst_n), .en(in_fire), .raw(f_lt),
    .now(now_w), .delay(delay_r), .q(lt_q)
  );

  pdb_bit_lane #(.TIME_BITS(TIME_BITS)) u_rt (
    .clk(clk), .rst_n(rst_n), .en(in_fire), .raw(f_rt),
    .now(now_w), .delay(delay_r), .q(rt_q)
  );

  pdb_axis_lane #(.TIME_BITS(TIME_BITS)) u_ax (
    .clk(clk), .rst_n(rst_n), .en(in_fire), .raw(f_ax),
    .now(now_w), .delay(delay_r), .q(ax_q)
  );

  pdb_axis_lane #(.TIME_BITS(TIME_BITS)) u_ay (
    .clk(clk), .rst_n(rst_n), .en(in_fire), .raw(f_ay),
    .now(now_w), .delay(delay_r), .q(ay_q)
  );

  assign res.buttons       = btn_out;
  assign res.left_trigger  = lt_q;
  assign res.right_trigger = rt_q;
  assign res.axis_x        = ax_q;
  assign res.axis_y        = ay_q;

  pdb_merge u_merge (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .res(res),
    .in_tready(in_tready), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .stat(stat)
  );

`ifndef ASSERT_OFF
  a_ready_tracks_skid: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == !stat.skid_valid)
    else $error("in_tready disagrees with skid occupancy");

  a_trigger_release: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !f_lt) |=> (out_tvalid && !stat.skid_valid) |-> !out_tdata[BTN_W])
    else $error("left trigger release not reported at once");

  a_axis_no_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[BTN_W+3:BTN_W+2] != 2'b10 && out_tdata[BTN_W+5:BTN_W+4] != 2'b10)
    else $error("axis result carries the unused pattern");
`endif

endmodule

@@ verif/tb_press_delay_debouncer_bank.sv @@
// tb_press_delay_debouncer_bank: self-checking bench for the press delay debouncer bank,
// with its own debounce predictor, random beat gaps and output stalls.
// depends on pdb_pkg and press_delay_debouncer_bank.
module tb_press_delay_debouncer_bank;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 67;

  typedef struct {
    logic [7:0]  buttons;
    logic        left_trigger;
    logic        right_trigger;
    logic [1:0]  axis_x;
    logic [1:0]  axis_y;
    logic [31:0] now_ms;
    bit          drain_first;
  } sample_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [pdb_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [pdb_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                          cfg_we = 1'b0;
  logic [pdb_pkg::DELAY_W-1:0]   cfg_wdata = '0;

  // predictor state: eight buttons, then left and right trigger
  logic [9:0]   chan_stable;
  logic [9:0]   chan_pending;
  logic [31:0]  chan_since [10];
  logic [1:0]   dir_stable [2];
  logic [1:0]   dir_pending [2];
  logic [31:0]  dir_since [2];
  logic [15:0]  hold_ms;

  sample_t           sample_q[$];
  pdb_pkg::result_t  debounced_q[$];
  sample_t           next_sample;
  pdb_pkg::result_t  got_beat;
  pdb_pkg::result_t  want_beat;
  logic [31:0] stamp_ms = '0;
  logic [15:0] hold_plan [6];
  int       queued_total = 0;
  int       results_seen = 0;
  int       sent_count = 0;
  int       send_gap = 0;
  int       ready_stall = 0;
  int       stall_cycles = 0;
  int       errors = 0;
  logic     in_accepted = 1'b0;

  press_delay_debouncer_bank uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic held_long(logic [31:0] since, logic [31:0] now);
    logic [31:0] elapsed;
    elapsed = now - since;
    return elapsed >= {16'd0, hold_ms};
  endfunction

  function automatic logic debounce_bit(int ch, logic raw, logic [31:0] now);
    if (raw == chan_stable[ch]) begin
      chan_pending[ch] = raw;
      chan_since[ch] = now;
    end else if (!raw) begin
      // release drops at once
      chan_stable[ch] = 1'b0;
      chan_pending[ch] = 1'b0;
      chan_since[ch] = now;
    end else if (chan_pending[ch] != raw) begin
      chan_pending[ch] = raw;
      chan_since[ch] = now;
    end else if (held_long(chan_since[ch], now)) begin
      chan_stable[ch] = raw;
    end
    return chan_stable[ch];
  endfunction

  function automatic logic [1:0] debounce_dir(int a, logic [1:0] code, logic [31:0] now);
    logic [1:0] dir;
    // pattern 10 saturates to the negative direction
    if (code == pdb_pkg::AXIS_IDLE) dir = pdb_pkg::AXIS_IDLE;
    else if (code == pdb_pkg::AXIS_POS) dir = pdb_pkg::AXIS_POS;
    else dir = pdb_pkg::AXIS_NEG;
    if (dir == dir_stable[a]) begin
      dir_pending[a] = dir;
      dir_since[a] = now;
    end else if (dir == pdb_pkg::AXIS_IDLE || dir_stable[a] != pdb_pkg::AXIS_IDLE) begin
      // release or reversal: back to idle, new direction starts its wait
      dir_stable[a] = pdb_pkg::AXIS_IDLE;
      dir_pending[a] = dir;
      dir_since[a] = now;
    end else if (dir_pending[a] != dir) begin
      dir_pending[a] = dir;
      dir_since[a] = now;
    end else if (held_long(dir_since[a], now)) begin
      dir_stable[a] = dir;
    end
    return dir_stable[a];
  endfunction

  function automatic pdb_pkg::result_t predict_result(logic [pdb_pkg::IN_DATA_W-1:0] beat);
    pdb_pkg::result_t r;
    logic [31:0]      now;
    now = beat[45:14];
    for (int i = 0; i < 8; i++) r.buttons[i] = debounce_bit(i, beat[i], now);
    r.axis_x = debounce_dir(0, beat[11:10], now);
    r.axis_y = debounce_dir(1, beat[13:12], now);
    r.left_trigger = debounce_bit(8, beat[8], now);
    r.right_trigger = debounce_bit(9, beat[9], now);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // timestamp advance, spread around the current hold time
  function automatic logic [31:0] hold_step();
    logic [31:0] d;
    d = {16'd0, hold_ms};
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1, 2, 3: return $urandom_range(0, d / 4 + 1);
      4, 5: return d;
      6: return (d == 0) ? 32'd0 : d - 1;
      7, 8: return d + $urandom_range(0, d + 2);
      default: return $urandom_range(0, 200);
    endcase
  endfunction

  task automatic flag_error(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic queue_fields(logic [7:0] b, logic lt, logic rt, logic [1:0] ax,
                              logic [1:0] ay, logic [31:0] at, bit drain);
    sample_t s;
    s.buttons = b;
    s.left_trigger = lt;
    s.right_trigger = rt;
    s.axis_x = ax;
    s.axis_y = ay;
    s.now_ms = at;
    s.drain_first = drain;
    sample_q.push_back(s);
    queued_total++;
  endtask

  task automatic set_hold(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    hold_ms = v;
  endtask

  task automatic wait_idle();
    while (results_seen != queued_total) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_random(int count);
    logic [7:0] b;
    logic       lt;
    logic       rt;
    logic [1:0] ax;
    logic [1:0] ay;
    int         left;
    bit         drain;
    b = 8'($urandom);
    lt = 1'($urandom);
    rt = 1'($urandom);
    ax = 2'($urandom);
    ay = 2'($urandom);
    left = count;
    drain = 1'b0;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        7: begin
          stamp_ms += $urandom_range(0, 50);
          queue_fields(8'($urandom), 1'($urandom), 1'($urandom), 2'($urandom),
                       2'($urandom), stamp_ms, drain);
          drain = 1'b0;
          left--;
        end
        8: begin
          // clock steps back, or jumps anywhere
          if ($urandom_range(0, 1)) stamp_ms -= $urandom_range(1, 40000);
          else stamp_ms = $urandom;
        end
        9: begin
          drain = 1'b1;
        end
        default: begin
          if ($urandom_range(0, 1)) b = 8'($urandom);
          else b ^= 8'd1 << $urandom_range(0, 7);
          if ($urandom_range(0, 2) == 0) lt = ~lt;
          if ($urandom_range(0, 2) == 0) rt = ~rt;
          if ($urandom_range(0, 2) == 0) ax = 2'($urandom);
          if ($urandom_range(0, 2) == 0) ay = 2'($urandom);
          repeat ($urandom_range(1, 6)) begin
            stamp_ms += hold_step();
            // occasional single-beat glitch inside a held run
            if ($urandom_range(0, 7) == 0)
              queue_fields(b ^ (8'd1 << $urandom_range(0, 7)), lt, ~rt, ax ^ 2'b01, ay,
                           stamp_ms, drain);
            else
              queue_fields(b, lt, rt, ax, ay, stamp_ms, drain);
            drain = 1'b0;
            left--;
          end
        end
      endcase
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_accepted)) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap--;
      end else if (sample_q.size() != 0 &&
                   !(sample_q[0].drain_first && debounced_q.size() != 0)) begin
        next_sample = sample_q.pop_front();
        in_tdata <= {{(pdb_pkg::IN_DATA_W - pdb_pkg::IN_FIELD_W){1'b0}}, next_sample.now_ms,
                     next_sample.axis_y, next_sample.axis_x, next_sample.right_trigger,
                     next_sample.left_trigger, next_sample.buttons};
        in_tvalid <= 1'b1;
        sent_count++;
        send_gap = (((sent_count / 48) % 4) == 2) ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (ready_stall > 0) begin
        out_tready <= 1'b0;
        ready_stall--;
      end else begin
        out_tready <= 1'b1;
        if (((results_seen / 48) % 4) != 1) ready_stall = pick_gap();
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got_beat = out_tdata[pdb_pkg::OUT_FIELD_W-1:0];
        if (debounced_q.size() == 0) begin
          flag_error($sformatf("result beat %h with nothing expected", got_beat));
        end else begin
          want_beat = debounced_q.pop_front();
          check_field("buttons", got_beat.buttons, want_beat.buttons);
          check_field("left_trigger", 8'(got_beat.left_trigger),
                      8'(want_beat.left_trigger));
          check_field("right_trigger", 8'(got_beat.right_trigger),
                      8'(want_beat.right_trigger));
          check_field("axis_x", 8'(got_beat.axis_x), 8'(want_beat.axis_x));
          check_field("axis_y", 8'(got_beat.axis_y), 8'(want_beat.axis_y));
        end
      end
      if (in_tvalid && in_tready) debounced_q.push_back(predict_result(in_tdata));
    end
    in_accepted <= rst_n && in_tvalid && in_tready;
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    @(posedge rst_n);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_press_delay_debouncer_bank: done, errors");
    $finish;
  end

  initial begin
    chan_stable = '0;
    chan_pending = '0;
    for (int i = 0; i < 10; i++) chan_since[i] = '0;
    for (int a = 0; a < 2; a++) begin
      dir_stable[a] = pdb_pkg::AXIS_IDLE;
      dir_pending[a] = pdb_pkg::AXIS_IDLE;
      dir_since[a] = '0;
    end
    hold_ms = pdb_pkg::DELAY_RESET;
    hold_plan = '{16'd0, 16'd1, 16'hFFFF, 16'd3, 16'd0, 16'd20};
    hold_plan[4] = 16'($urandom_range(0, 65535));

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, at the reset hold time of 20 ms
    queue_fields(8'h00, 1'b0, 1'b0, pdb_pkg::AXIS_IDLE, pdb_pkg::AXIS_IDLE, 32'd0, 1'b0);
    queue_fields(8'hFF, 1'b1, 1'b1, pdb_pkg::AXIS_POS, pdb_pkg::AXIS_NEG, 32'd0, 1'b0);
    queue_fields(8'hFF, 1'b1, 1'b1, pdb_pkg::AXIS_POS, pdb_pkg::AXIS_NEG, 32'd19, 1'b0);
    queue_fields(8'hFF, 1'b1, 1'b1, pdb_pkg::AXIS_POS, pdb_pkg::AXIS_NEG, 32'd20, 1'b0);
    // release buttons, left trigger and x, keep right trigger, reverse y
    queue_fields(8'h00, 1'b0, 1'b1, pdb_pkg::AXIS_IDLE, pdb_pkg::AXIS_POS, 32'd21, 1'b0);
    queue_fields(8'h55, 1'b0, 1'b1, pdb_pkg::AXIS_IDLE, pdb_pkg::AXIS_POS, 32'd41, 1'b0);
    queue_fields(8'hAA, 1'b1, 1'b0, 2'b10, pdb_pkg::AXIS_POS, 32'd45, 1'b0);
    queue_fields(8'hAA, 1'b1, 1'b0, pdb_pkg::AXIS_NEG, pdb_pkg::AXIS_POS, 32'd70, 1'b0);
    // timestamp going backwards reads as a long hold
    queue_fields(8'hFF, 1'b1, 1'b0, pdb_pkg::AXIS_NEG, pdb_pkg::AXIS_NEG, 32'd10, 1'b0);
    queue_fields(8'hFF, 1'b1, 1'b0, pdb_pkg::AXIS_NEG, pdb_pkg::AXIS_NEG, 32'd5, 1'b0);
    // wrap of the millisecond counter
    queue_fields(8'h00, 1'b0, 1'b0, pdb_pkg::AXIS_IDLE, pdb_pkg::AXIS_IDLE, 32'hFFFF_FFF0,
                 1'b0);
    queue_fields(8'h0F, 1'b1, 1'b1, pdb_pkg::AXIS_POS, 2'b10, 32'hFFFF_FFF8, 1'b0);
    queue_fields(8'h0F, 1'b1, 1'b1, pdb_pkg::AXIS_POS, 2'b10, 32'hFFFF_FFFF, 1'b0);
    queue_fields(8'h0F, 1'b1, 1'b1, pdb_pkg::AXIS_POS, 2'b10, 32'h0000_000B, 1'b0);
    queue_fields(8'h0F, 1'b1, 1'b1, pdb_pkg::AXIS_POS, 2'b10, 32'h0000_000C, 1'b1);
    wait_idle();

    foreach (hold_plan[p]) begin
      set_hold(hold_plan[p]);
      @(posedge clk);
      if (p == 0) begin
        // zero hold: second beat of the same press reports it
        queue_fields(8'h01, 1'b1, 1'b0, pdb_pkg::AXIS_POS, pdb_pkg::AXIS_IDLE, 32'd100, 1'b0);
        queue_fields(8'h01, 1'b1, 1'b0, pdb_pkg::AXIS_POS, pdb_pkg::AXIS_IDLE, 32'd100, 1'b0);
        stamp_ms = 32'd100;
      end
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    if (debounced_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", debounced_q.size()));
    if (errors == 0)
      $display("tb_press_delay_debouncer_bank: done, clean");
    else
      $display("tb_press_delay_debouncer_bank: done, errors");
    $finish;
  end

endmodule
